@@ hw/rtl/uart_register_block_top_defines.svh @@
// Assertion macros shared by the checker of the UART register block.
`ifndef UART_REGISTER_BLOCK_TOP_DEFINES_SVH
`define UART_REGISTER_BLOCK_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define URB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("urb check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define URB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("urb check failed");

`endif

@@ hw/rtl/urb_pkg.sv @@
// Package with types, constants and helper functions of the UART register block.
`default_nettype none
package urb_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RX    = 2'd2,
    KIND_SHIFT = 2'd3
  } kind_t;

  localparam logic [2:0] OFF_DATA    = 3'd0;
  localparam logic [2:0] OFF_IER     = 3'd1;
  localparam logic [2:0] OFF_IIR_FCR = 3'd2;
  localparam logic [2:0] OFF_LCR     = 3'd3;
  localparam logic [2:0] OFF_MCR     = 3'd4;
  localparam logic [2:0] OFF_LSR     = 3'd5;
  localparam logic [2:0] OFF_MSR     = 3'd6;
  localparam logic [2:0] OFF_SCR     = 3'd7;

  localparam logic [7:0] IIR_NONE      = 8'h01;
  localparam logic [7:0] IIR_THRE      = 8'h02;
  localparam logic [7:0] IIR_RX_DATA   = 8'h04;
  localparam logic [7:0] IIR_LINE_STAT = 8'h06;
  localparam logic [7:0] IIR_FIFO_BITS = 8'hC0;

  localparam logic [7:0] LSR_DR       = 8'h01;
  localparam logic [7:0] LSR_OE       = 8'h02;
  localparam logic [7:0] LSR_TX_EMPTY = 8'h20;
  localparam logic [7:0] LSR_TX_IDLE  = 8'h40;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] line_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq;
    logic        tx_start;
    logic [7:0]  tx_byte;
    logic [15:0] baud_divisor;
    logic [6:0]  line_format;
    logic [4:0]  modem_lines;
  } out_item_t;

  function automatic logic [CNT_W-1:0] trig_level(input logic on, input logic [1:0] sel);
    int t;
    case (sel)
      2'd0:    t = 1;
      2'd1:    t = 4;
      2'd2:    t = 8;
      default: t = 14;
    endcase
    if (t > FIFO_DEPTH) t = FIFO_DEPTH;
    if (!on) t = 1;
    return CNT_W'(t);
  endfunction

  function automatic logic [7:0] iir_value(input logic [3:0] ie, input logic overrun,
                                           input logic [CNT_W-1:0] rx_cnt,
                                           input logic [CNT_W-1:0] trig,
                                           input logic thre, input logic on);
    logic [7:0] v;
    if (ie[2] && overrun) v = IIR_LINE_STAT;
    else if (ie[0] && (rx_cnt >= trig)) v = IIR_RX_DATA;
    else if (ie[1] && thre) v = IIR_THRE;
    else v = IIR_NONE;
    if (on) v = v | IIR_FIFO_BITS;
    return v;
  endfunction

  // Slot of head plus count, wrapped once; the sum stays below twice the depth.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(cnt);
    if (s >= (CNT_W+1)'(FIFO_DEPTH)) s = s - (CNT_W+1)'(FIFO_DEPTH);
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] head);
    logic [PTR_W-1:0] r;
    if (head == PTR_W'(FIFO_DEPTH - 1)) r = '0;
    else r = head + PTR_W'(1);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/urb_if.sv @@
// Valid/ready channel interfaces that carry input items and result items.
`default_nettype none
interface urb_in_if;
  logic valid;
  logic ready;
  urb_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface urb_out_if;
  logic valid;
  logic ready;
  urb_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/urb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module urb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/uart_register_block_top.sv @@
// Top level of the 16550A-style UART register block with its receive and transmit FIFOs.
// Each item gives its result item in the cycle after it is accepted.
// One item per cycle while the output takes results; the result register drains while the next item enters.
// The FIFO bytes live in two RAMs with registered read data, read at acceptance.
// Reset clears the state registers, counters and result valid flag, not the result payload;
// the FIFO RAMs are not cleared, since the counters keep any unwritten entry from being read.
`default_nettype none
module uart_register_block_top (
  input  wire logic  clk,
  input  wire logic  rst,
  urb_in_if.sink     req,
  urb_out_if.source  rsp
);
  import urb_pkg::*;

  // Architectural state, all in flip-flops except the FIFO bytes.
  logic [PTR_W-1:0] rx_head, rx_head_next, tx_head, tx_head_next;
  logic [CNT_W-1:0] rx_count, rx_count_next, tx_count, tx_count_next;
  logic             shifter_busy, shifter_busy_next;
  logic [3:0]       int_enable, int_enable_next;
  logic [7:0]       line_ctrl, line_ctrl_next;
  logic [4:0]       modem_ctrl, modem_ctrl_next;
  logic [7:0]       scratch_byte, scratch_byte_next;
  logic [15:0]      divisor_latch, divisor_latch_next;
  logic             fifo_on, fifo_on_next;
  logic [1:0]       trigger_sel, trigger_sel_next;
  logic             overrun_flag, overrun_flag_next;
  logic             thre_pending, thre_pending_next;

  // Result register: holds everything of the item except bytes still in RAM.
  logic             res_valid;
  logic [7:0]       res_rd;
  logic             res_rd_rx;
  logic             res_irq;
  logic             res_start;
  logic             res_bypass;
  logic [7:0]       res_bypass_byte;
  logic [15:0]      res_div;
  logic [6:0]       res_fmt;
  logic [4:0]       res_mcr;

  // RAM ports.
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [PTR_W-1:0] rx_waddr, tx_waddr;
  logic [7:0]       rx_wdata, tx_wdata, rx_rdata, tx_rdata;

  // Per-item combinational results.
  logic [7:0]       step_rd;
  logic             step_rd_rx;
  logic             step_start;
  logic             step_bypass;
  logic             step_irq;

  logic             accept;
  logic             dlab;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] tc;
  logic             try_load;
  logic             busy_v;
  logic [7:0]       iir_now;
  logic [7:0]       lsr_now;
  logic [7:0]       iir_next;
  kind_t            kind;

  // A new item enters whenever the result register is empty or being taken.
  assign req.ready = !res_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign kind      = kind_t'(req.data.kind);

  assign dlab    = line_ctrl[7];
  assign cap     = fifo_on ? CNT_W'(FIFO_DEPTH) : CNT_W'(1);
  assign iir_now = iir_value(int_enable, overrun_flag, rx_count,
                             trig_level(fifo_on, trigger_sel), thre_pending, fifo_on);

  always_comb begin
    lsr_now = 8'h00;
    if (rx_count != '0) lsr_now = lsr_now | LSR_DR;
    if (overrun_flag) lsr_now = lsr_now | LSR_OE;
    if (tx_count == '0) begin
      lsr_now = lsr_now | LSR_TX_EMPTY;
      if (!shifter_busy) lsr_now = lsr_now | LSR_TX_IDLE;
    end
  end

  // One event per accepted item: update the state, issue the RAM accesses.
  always_comb begin
    rx_head_next       = rx_head;
    rx_count_next      = rx_count;
    tx_head_next       = tx_head;
    tx_count_next      = tx_count;
    shifter_busy_next  = shifter_busy;
    int_enable_next    = int_enable;
    line_ctrl_next     = line_ctrl;
    modem_ctrl_next    = modem_ctrl;
    scratch_byte_next  = scratch_byte;
    divisor_latch_next = divisor_latch;
    fifo_on_next       = fifo_on;
    trigger_sel_next   = trigger_sel;
    overrun_flag_next  = overrun_flag;
    thre_pending_next  = thre_pending;
    step_rd     = 8'h00;
    step_rd_rx  = 1'b0;
    step_start  = 1'b0;
    step_bypass = 1'b0;
    rx_we = 1'b0; rx_re = 1'b0; tx_we = 1'b0; tx_re = 1'b0;
    rx_waddr = wrap_add(rx_head, rx_count);
    rx_wdata = req.data.line_byte;
    tx_waddr = wrap_add(tx_head, tx_count);
    tx_wdata = req.data.write_data;
    tc       = tx_count;
    try_load = 1'b0;
    busy_v   = shifter_busy;

    case (kind)
      KIND_READ: begin
        case (req.data.reg_offset)
          OFF_DATA: begin
            if (dlab) begin
              step_rd = divisor_latch[7:0];
            end else if (rx_count != '0) begin
              // The byte comes out of the registered RAM read port.
              rx_re         = accept;
              step_rd_rx    = 1'b1;
              rx_head_next  = wrap_inc(rx_head);
              rx_count_next = rx_count - CNT_W'(1);
            end
          end
          OFF_IER:     step_rd = dlab ? divisor_latch[15:8] : {4'h0, int_enable};
          OFF_IIR_FCR: begin
            step_rd = iir_now;
            if (step_rd[3:0] == IIR_THRE[3:0]) thre_pending_next = 1'b0;
          end
          OFF_LCR:     step_rd = line_ctrl;
          OFF_MCR:     step_rd = {3'b000, modem_ctrl};
          OFF_LSR: begin
            step_rd           = lsr_now;
            overrun_flag_next = 1'b0;
          end
          OFF_MSR:     step_rd = 8'h00;
          default:     step_rd = scratch_byte;
        endcase
      end
      KIND_WRITE: begin
        case (req.data.reg_offset)
          OFF_DATA: begin
            if (dlab) begin
              divisor_latch_next[7:0] = req.data.write_data;
            end else begin
              thre_pending_next = 1'b0;
              if (tx_count < cap) begin
                tx_we = accept;
                tc    = tx_count + CNT_W'(1);
              end
              try_load = 1'b1;
            end
          end
          OFF_IER: begin
            if (dlab) begin
              divisor_latch_next[15:8] = req.data.write_data;
            end else begin
              if (req.data.write_data[1] && !int_enable[1] && tx_count == '0)
                thre_pending_next = 1'b1;
              int_enable_next = req.data.write_data[3:0];
            end
          end
          OFF_IIR_FCR: begin
            if (req.data.write_data[0] != fifo_on || req.data.write_data[1]) begin
              rx_head_next  = '0;
              rx_count_next = '0;
            end
            if (req.data.write_data[0] != fifo_on || req.data.write_data[2]) begin
              if (tx_count != '0) thre_pending_next = 1'b1;
              tx_head_next  = '0;
              tx_count_next = '0;
            end
            fifo_on_next     = req.data.write_data[0];
            trigger_sel_next = req.data.write_data[7:6];
          end
          OFF_LCR: line_ctrl_next    = req.data.write_data;
          OFF_MCR: modem_ctrl_next   = req.data.write_data[4:0];
          OFF_SCR: scratch_byte_next = req.data.write_data;
          default: ;
        endcase
      end
      KIND_RX: begin
        if (rx_count < cap) begin
          rx_we         = accept;
          rx_count_next = rx_count + CNT_W'(1);
        end else begin
          overrun_flag_next = 1'b1;
          if (!fifo_on) begin
            // Single holding byte is overwritten in place.
            rx_we    = accept;
            rx_waddr = rx_head;
          end
        end
      end
      default: begin
        busy_v            = 1'b0;
        shifter_busy_next = 1'b0;
        try_load          = 1'b1;
      end
    endcase

    // Hand the oldest transmit byte to an idle shifter.
    if (try_load) begin
      tx_count_next = tc;
      if (!busy_v && tc != '0) begin
        tx_re             = accept;
        step_start        = 1'b1;
        // A byte written into an empty store is read in the same step.
        step_bypass       = tx_we && (tx_count == '0);
        tx_head_next      = wrap_inc(tx_head);
        tx_count_next     = tc - CNT_W'(1);
        shifter_busy_next = 1'b1;
        if (tx_count_next == '0) thre_pending_next = 1'b1;
      end
    end

    iir_next = iir_value(int_enable_next, overrun_flag_next, rx_count_next,
                         trig_level(fifo_on_next, trigger_sel_next),
                         thre_pending_next, fifo_on_next);
    step_irq = !iir_next[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head       <= '0;
      rx_count      <= '0;
      tx_head       <= '0;
      tx_count      <= '0;
      shifter_busy  <= 1'b0;
      int_enable    <= '0;
      line_ctrl     <= '0;
      modem_ctrl    <= '0;
      scratch_byte  <= '0;
      divisor_latch <= '0;
      fifo_on       <= 1'b0;
      trigger_sel   <= '0;
      overrun_flag  <= 1'b0;
      thre_pending  <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (accept) begin
        rx_head       <= rx_head_next;
        rx_count      <= rx_count_next;
        tx_head       <= tx_head_next;
        tx_count      <= tx_count_next;
        shifter_busy  <= shifter_busy_next;
        int_enable    <= int_enable_next;
        line_ctrl     <= line_ctrl_next;
        modem_ctrl    <= modem_ctrl_next;
        scratch_byte  <= scratch_byte_next;
        divisor_latch <= divisor_latch_next;
        fifo_on       <= fifo_on_next;
        trigger_sel   <= trigger_sel_next;
        overrun_flag  <= overrun_flag_next;
        thre_pending  <= thre_pending_next;
      end
      if (accept) res_valid <= 1'b1;
      else if (rsp.ready) res_valid <= 1'b0;
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_rd          <= step_rd;
      res_rd_rx       <= step_rd_rx;
      res_irq         <= step_irq;
      res_start       <= step_start;
      res_bypass      <= step_bypass;
      res_bypass_byte <= req.data.write_data;
      res_div         <= divisor_latch_next;
      res_fmt         <= line_ctrl_next[6:0];
      res_mcr         <= modem_ctrl_next;
    end
  end

  urb_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (rx_wdata),
    .re    (rx_re),
    .raddr (rx_head),
    .rdata (rx_rdata)
  );

  urb_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .re    (tx_re),
    .raddr (tx_head),
    .rdata (tx_rdata)
  );

  // The RAMs are read only on acceptance, so their data hold while the result stalls.
  assign rsp.valid             = res_valid;
  assign rsp.data.read_data    = res_rd_rx ? rx_rdata : res_rd;
  assign rsp.data.irq          = res_irq;
  assign rsp.data.tx_start     = res_start;
  assign rsp.data.tx_byte      = !res_start ? 8'h00 : (res_bypass ? res_bypass_byte : tx_rdata);
  assign rsp.data.baud_divisor = res_div;
  assign rsp.data.line_format  = res_fmt;
  assign rsp.data.modem_lines  = res_mcr;
endmodule
`default_nettype wire

@@ hw/rtl/urb_checker.sv @@
// Port-level checker of the UART register block and its bind to the top level.
`default_nettype none
`include "uart_register_block_top_defines.svh"
module urb_port_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_tx_start,
  input wire logic [7:0] out_tx_byte
);
  // Every accepted item shows its result on the next cycle.
  `URB_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid)
  // A result that is not taken stays offered.
  `URB_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid)
  // The shifter byte is zero unless a byte is handed over.
  `URB_ASSERT_NOW(a_tx_byte_zero, out_valid && !out_tx_start, out_tx_byte == 8'h00)
endmodule

bind uart_register_block_top urb_port_checker u_urb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (req.valid),
  .in_ready     (req.ready),
  .out_valid    (rsp.valid),
  .out_ready    (rsp.ready),
  .out_tx_start (rsp.data.tx_start),
  .out_tx_byte  (rsp.data.tx_byte)
);
`default_nettype wire
